>>> design/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// shared types and constants of the tcp flow tracker and classifier
// ----------------------------------------------------------------------------
package tfc_pkg;

   localparam logic [7:0] FL_FIN = 8'h01;
   localparam logic [7:0] FL_SYN = 8'h02;
   localparam logic [7:0] FL_RST = 8'h04;
   localparam logic [7:0] FL_ACK = 8'h10;

   localparam logic [1:0] PROTO_TCP  = 2'd0;
   localparam logic [1:0] PROTO_ICMP = 2'd1;

   localparam logic [1:0] CSR_PEER_IP     = 2'd0;
   localparam logic [1:0] CSR_FILTER_ON   = 2'd1;
   localparam logic [1:0] CSR_REQUIRE_PRT = 2'd2;
   localparam logic [1:0] CSR_PEER_PORT   = 2'd3;

   localparam logic [1:0] RST_NONE = 2'd0;
   localparam logic [1:0] RST_INIT = 2'd1;
   localparam logic [1:0] RST_RESP = 2'd2;

   localparam logic [3:0] CASE_REFUSED      = 4'd0;
   localparam logic [3:0] CASE_RST_DATA     = 4'd1;
   localparam logic [3:0] CASE_ABN_RST      = 4'd2;
   localparam logic [3:0] CASE_CLOSED       = 4'd3;
   localparam logic [3:0] CASE_FIN_NOBIDIR  = 4'd4;
   localparam logic [3:0] CASE_SYN_UNANS    = 4'd5;
   localparam logic [3:0] CASE_HALF_HS      = 4'd6;
   localparam logic [3:0] CASE_EST_BIDIR    = 4'd7;
   localparam logic [3:0] CASE_EST_ONEWAY   = 4'd8;
   localparam logic [3:0] CASE_EST_IDLE     = 4'd9;
   localparam logic [3:0] CASE_MID_BIDIR    = 4'd10;
   localparam logic [3:0] CASE_MID_ONEWAY   = 4'd11;
   localparam logic [3:0] CASE_INSUFFICIENT = 4'd12;

   localparam logic [1:0] LVL_NORMAL  = 2'd0;
   localparam logic [1:0] LVL_WARNING = 2'd1;
   localparam logic [1:0] LVL_ERROR   = 2'd2;
   localparam logic [1:0] LVL_UNKNOWN = 2'd3;

   localparam logic [1:0] CONF_LOW  = 2'd0;
   localparam logic [1:0] CONF_MED  = 2'd1;
   localparam logic [1:0] CONF_HIGH = 2'd2;

   localparam logic [1:0] SYN_MANY = 2'd3;

   // summary of a slot after update, as seen by the classifier
   typedef struct packed {
      logic       init_known;
      logic       hs;
      logic       syn_nz;
      logic       syn_many;
      logic       synack_nz;
      logic       rst_i_nz;
      logic       rst_r_nz;
      logic [1:0] first_rst;
      logic       fin_i_nz;
      logic       fin_r_nz;
      logic       data_i_nz;
      logic       data_r_nz;
   } flow_view_type;

   typedef struct packed {
      logic [3:0] dcase;
      logic [1:0] level;
      logic [1:0] conf;
   } diag_type;

endpackage

>>> design/tcp_flow_tracker_classifier_core.sv
// ----------------------------------------------------------------------------
// tcp_flow_tracker_classifier_core
// peer filter, flow slot table and flow diagnosis; unless the output stalls, one header per cycle
// ----------------------------------------------------------------------------
// Each header transaction is registered on entry, then matched in parallel
// against all FLOW_SLOTS slots, updated and classified from that register,
// and its result transaction is registered on the rsp_ side. One header is
// taken per cycle while the output is not stalled; the figure is set by the
// parallel slot match and slot write-back. The input register takes a new
// header while a result waits, as long as it is not already holding a header
// behind the stalled output. Slot counters saturate at 2^COUNT_BITS-1,
// payload packet counts at 2^32-1.
module tcp_flow_tracker_classifier_core #(
   parameter int FLOW_SLOTS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_pkt_valid,
   input  logic [1:0]  req_proto_kind,
   input  logic [31:0] req_src_addr,
   input  logic [15:0] req_src_port_num,
   input  logic [31:0] req_dst_addr,
   input  logic [15:0] req_dst_port_num,
   input  logic [7:0]  req_flag_bits,
   input  logic [15:0] req_payload_len,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic        rsp_tracked,
   output logic        rsp_table_full,
   output logic        rsp_new_flow,
   output logic [3:0]  rsp_slot_index,
   output logic        rsp_origin_known,
   output logic        rsp_handshake_done,
   output logic [3:0]  rsp_diag_case,
   output logic [1:0]  rsp_diag_level,
   output logic [1:0]  rsp_diag_confidence
);
   localparam int SW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // configuration
   logic [31:0] peer_ip_ff;
   logic        filter_on_ff, require_port_ff;
   logic [15:0] peer_port_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         peer_ip_ff      <= '0;
         filter_on_ff    <= 1'b0;
         require_port_ff <= 1'b0;
         peer_port_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tfc_pkg::CSR_PEER_IP:     peer_ip_ff      <= csr_wdata;
            tfc_pkg::CSR_FILTER_ON:   filter_on_ff    <= csr_wdata[0];
            tfc_pkg::CSR_REQUIRE_PRT: require_port_ff <= csr_wdata[0];
            tfc_pkg::CSR_PEER_PORT:   peer_port_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // input register stage
   logic        s1_valid_ff;
   logic        pv_ff;
   logic [1:0]  proto_ff;
   logic [31:0] sa_ff, da_ff;
   logic [15:0] sp_ff, dp_ff, plen_ff;
   logic [7:0]  fl_ff;
   logic        s1_go;

   // s1 advances whenever the output register is free or being emptied
   assign s1_go     = !(rsp_valid && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (!req_stall) s1_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         pv_ff    <= req_pkt_valid;
         proto_ff <= req_proto_kind;
         sa_ff    <= req_src_addr;
         sp_ff    <= req_src_port_num;
         da_ff    <= req_dst_addr;
         dp_ff    <= req_dst_port_num;
         fl_ff    <= req_flag_bits;
         plen_ff  <= req_payload_len;
      end
   end

   // slot table
   logic [FLOW_SLOTS-1:0]  used_ff;
   logic [31:0]            iip_ff [FLOW_SLOTS];
   logic [15:0]            ipt_ff [FLOW_SLOTS];
   logic [31:0]            rip_ff [FLOW_SLOTS];
   logic [15:0]            rpt_ff [FLOW_SLOTS];
   logic                   ikn_ff [FLOW_SLOTS];
   logic [COUNT_BITS-1:0]  syn_ff [FLOW_SLOTS];
   logic [COUNT_BITS-1:0]  sak_ff [FLOW_SLOTS];
   logic                   hs_ff  [FLOW_SLOTS];
   logic [COUNT_BITS-1:0]  rsti_ff[FLOW_SLOTS];
   logic [COUNT_BITS-1:0]  rstr_ff[FLOW_SLOTS];
   logic [1:0]             frst_ff[FLOW_SLOTS];
   logic [COUNT_BITS-1:0]  fini_ff[FLOW_SLOTS];
   logic [COUNT_BITS-1:0]  finr_ff[FLOW_SLOTS];
   logic [31:0]            dati_ff[FLOW_SLOTS];
   logic [31:0]            datr_ff[FLOW_SLOTS];

   // filter
   logic pass, is_tcp, syn, ack, do_work;
   always_comb begin
      pass = pv_ff;
      if (filter_on_ff && sa_ff != peer_ip_ff && da_ff != peer_ip_ff) pass = 1'b0;
      if (require_port_ff) begin
         if (proto_ff != tfc_pkg::PROTO_TCP) begin
            if (proto_ff != tfc_pkg::PROTO_ICMP) pass = 1'b0;
         end else if (peer_port_ff == '0) begin
            pass = 1'b0;
         end else if (sp_ff != peer_port_ff && dp_ff != peer_port_ff) begin
            pass = 1'b0;
         end
      end
      is_tcp  = proto_ff == tfc_pkg::PROTO_TCP;
      syn     = (fl_ff & tfc_pkg::FL_SYN) != 8'h00;
      ack     = (fl_ff & tfc_pkg::FL_ACK) != 8'h00;
      do_work = s1_valid_ff && s1_go && pass && is_tcp;
   end

   // parallel match and lowest-free search
   logic [FLOW_SLOTS-1:0] hit, free;
   logic [SW-1:0] hit_idx, free_idx, s_idx;
   logic          any_hit, any_free, found, fresh;
   always_comb begin
      any_hit = 1'b0; any_free = 1'b0; hit_idx = '0; free_idx = '0;
      for (int i = FLOW_SLOTS - 1; i >= 0; i--) begin
         hit[i] = used_ff[i] &&
            ((sa_ff == iip_ff[i] && sp_ff == ipt_ff[i] && da_ff == rip_ff[i] &&
              dp_ff == rpt_ff[i]) ||
             (sa_ff == rip_ff[i] && sp_ff == rpt_ff[i] && da_ff == iip_ff[i] &&
              dp_ff == ipt_ff[i]));
         free[i] = !used_ff[i];
         if (hit[i])  begin any_hit = 1'b1;  hit_idx  = SW'(i); end
         if (free[i]) begin any_free = 1'b1; free_idx = SW'(i); end
      end
      found = any_hit || any_free;
      fresh = !any_hit && any_free;
      s_idx = any_hit ? hit_idx : free_idx;
   end

   // current (post-allocation) view of the chosen slot
   logic [31:0] c_iip, c_rip, c_dati, c_datr;
   logic [15:0] c_ipt, c_rpt;
   logic        c_ikn, c_hs;
   logic [COUNT_BITS-1:0] c_syn, c_sak, c_rsti, c_rstr, c_fini, c_finr;
   logic [1:0]  c_frst;
   always_comb begin
      if (fresh) begin
         if (syn && ack) begin
            c_iip = da_ff; c_ipt = dp_ff; c_rip = sa_ff; c_rpt = sp_ff; c_ikn = 1'b1;
         end else begin
            c_iip = sa_ff; c_ipt = sp_ff; c_rip = da_ff; c_rpt = dp_ff;
            c_ikn = syn && !ack;
         end
         c_syn = '0; c_sak = '0; c_hs = 1'b0; c_rsti = '0; c_rstr = '0;
         c_frst = tfc_pkg::RST_NONE; c_fini = '0; c_finr = '0; c_dati = '0; c_datr = '0;
      end else begin
         c_iip = iip_ff[s_idx]; c_ipt = ipt_ff[s_idx];
         c_rip = rip_ff[s_idx]; c_rpt = rpt_ff[s_idx]; c_ikn = ikn_ff[s_idx];
         c_syn = syn_ff[s_idx]; c_sak = sak_ff[s_idx]; c_hs = hs_ff[s_idx];
         c_rsti = rsti_ff[s_idx]; c_rstr = rstr_ff[s_idx]; c_frst = frst_ff[s_idx];
         c_fini = fini_ff[s_idx]; c_finr = finr_ff[s_idx];
         c_dati = dati_ff[s_idx]; c_datr = datr_ff[s_idx];
      end
   end

   // update
   logic from_i, from_r;
   logic [31:0] n_dati, n_datr;
   logic        n_ikn, n_hs;
   logic [COUNT_BITS-1:0] n_syn, n_sak, n_rsti, n_rstr, n_fini, n_finr;
   logic [1:0]  n_frst;
   always_comb begin
      from_i = sa_ff == c_iip && sp_ff == c_ipt;
      from_r = sa_ff == c_rip && sp_ff == c_rpt;
      n_ikn = c_ikn; n_syn = c_syn; n_sak = c_sak; n_hs = c_hs;
      n_rsti = c_rsti; n_rstr = c_rstr; n_frst = c_frst;
      n_fini = c_fini; n_finr = c_finr; n_dati = c_dati; n_datr = c_datr;
      if (syn && !ack) begin
         if (from_i) begin
            n_ikn = 1'b1;
            if (c_syn != CNT_MAX) n_syn = c_syn + 1'b1;
         end
      end else if (syn && ack) begin
         if (from_r && c_sak != CNT_MAX) n_sak = c_sak + 1'b1;
      end else if (ack) begin
         if (from_i && c_sak != '0) n_hs = 1'b1;
      end
      if ((fl_ff & tfc_pkg::FL_RST) != 8'h00) begin
         if (c_frst == tfc_pkg::RST_NONE)
            n_frst = from_r ? tfc_pkg::RST_RESP : tfc_pkg::RST_INIT;
         if (from_i) begin
            if (c_rsti != CNT_MAX) n_rsti = c_rsti + 1'b1;
         end else if (from_r) begin
            if (c_rstr != CNT_MAX) n_rstr = c_rstr + 1'b1;
         end
      end
      if ((fl_ff & tfc_pkg::FL_FIN) != 8'h00) begin
         if (from_i) begin
            if (c_fini != CNT_MAX) n_fini = c_fini + 1'b1;
         end else if (from_r) begin
            if (c_finr != CNT_MAX) n_finr = c_finr + 1'b1;
         end
      end
      if (plen_ff != '0) begin
         if (from_i) begin
            if (c_dati != 32'hFFFF_FFFF) n_dati = c_dati + 32'd1;
         end else if (from_r) begin
            if (c_datr != 32'hFFFF_FFFF) n_datr = c_datr + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else if (do_work && fresh) used_ff[s_idx] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_work && found) begin
         iip_ff[s_idx]  <= c_iip;  ipt_ff[s_idx]  <= c_ipt;
         rip_ff[s_idx]  <= c_rip;  rpt_ff[s_idx]  <= c_rpt;
         ikn_ff[s_idx]  <= n_ikn;  syn_ff[s_idx]  <= n_syn;
         sak_ff[s_idx]  <= n_sak;  hs_ff[s_idx]   <= n_hs;
         rsti_ff[s_idx] <= n_rsti; rstr_ff[s_idx] <= n_rstr;
         frst_ff[s_idx] <= n_frst; fini_ff[s_idx] <= n_fini;
         finr_ff[s_idx] <= n_finr; dati_ff[s_idx] <= n_dati;
         datr_ff[s_idx] <= n_datr;
      end
   end

   // classification of the updated slot
   tfc_pkg::flow_view_type view;
   tfc_pkg::diag_type      diag;
   always_comb begin
      view.init_known = n_ikn;
      view.hs         = n_hs;
      view.syn_nz     = n_syn != '0;
      view.syn_many   = 32'(n_syn) >= 32'(tfc_pkg::SYN_MANY);
      view.synack_nz  = n_sak != '0;
      view.rst_i_nz   = n_rsti != '0;
      view.rst_r_nz   = n_rstr != '0;
      view.first_rst  = n_frst;
      view.fin_i_nz   = n_fini != '0;
      view.fin_r_nz   = n_finr != '0;
      view.data_i_nz  = n_dati != '0;
      view.data_r_nz  = n_datr != '0;
   end

   tfc_classify u_classify (.view(view), .diag(diag));

   // result register
   logic       valid_ff, acc_ff, trk_ff, full_ff, new_ff, ok_ff, hsd_ff;
   logic [3:0] slot_ff, case_ff;
   logic [1:0] lvl_ff, conf_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (s1_go) valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_valid_ff) begin
         acc_ff  <= pass;
         trk_ff  <= 1'b0; full_ff <= 1'b0; new_ff <= 1'b0;
         slot_ff <= '0;   ok_ff   <= 1'b0; hsd_ff <= 1'b0;
         case_ff <= pass ? tfc_pkg::CASE_INSUFFICIENT : '0;
         lvl_ff  <= pass ? tfc_pkg::LVL_UNKNOWN : '0;
         conf_ff <= tfc_pkg::CONF_LOW;
         if (pass && is_tcp) begin
            if (!found) begin
               full_ff <= 1'b1;
            end else begin
               trk_ff  <= 1'b1;
               new_ff  <= fresh;
               slot_ff <= 4'(s_idx);
               ok_ff   <= n_ikn;
               hsd_ff  <= n_hs;
               case_ff <= diag.dcase;
               lvl_ff  <= diag.level;
               conf_ff <= diag.conf;
            end
         end
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_accepted        = acc_ff;
   assign rsp_tracked         = trk_ff;
   assign rsp_table_full      = full_ff;
   assign rsp_new_flow        = new_ff;
   assign rsp_slot_index      = slot_ff;
   assign rsp_origin_known    = ok_ff;
   assign rsp_handshake_done  = hsd_ff;
   assign rsp_diag_case       = case_ff;
   assign rsp_diag_level      = lvl_ff;
   assign rsp_diag_confidence = conf_ff;
endmodule

>>> design/tfc_classify.sv
// ----------------------------------------------------------------------------
// tfc_classify
// maps a flow summary onto diagnosis case, level and confidence
// ----------------------------------------------------------------------------
module tfc_classify (
   input  tfc_pkg::flow_view_type view,
   output tfc_pkg::diag_type      diag
);
   logic any_pl, both_pl, any_rst, any_fin;

   always_comb begin
      any_pl  = view.data_i_nz | view.data_r_nz;
      both_pl = view.data_i_nz & view.data_r_nz;
      any_rst = view.rst_i_nz | view.rst_r_nz;
      any_fin = view.fin_i_nz | view.fin_r_nz;
      diag = '{tfc_pkg::CASE_INSUFFICIENT, tfc_pkg::LVL_UNKNOWN, tfc_pkg::CONF_LOW};
      priority if (any_rst) begin
         if (view.init_known && view.first_rst == tfc_pkg::RST_RESP && !view.hs &&
             view.syn_nz && !view.synack_nz)
            diag = '{tfc_pkg::CASE_REFUSED, tfc_pkg::LVL_ERROR, tfc_pkg::CONF_HIGH};
         else if (both_pl)
            diag = '{tfc_pkg::CASE_RST_DATA, tfc_pkg::LVL_WARNING, tfc_pkg::CONF_HIGH};
         else
            diag = '{tfc_pkg::CASE_ABN_RST, tfc_pkg::LVL_ERROR, tfc_pkg::CONF_HIGH};
      end else if (any_fin && (view.hs || any_pl)) begin
         if (both_pl)
            diag = '{tfc_pkg::CASE_CLOSED, tfc_pkg::LVL_NORMAL,
                     (view.fin_i_nz && view.fin_r_nz) ? tfc_pkg::CONF_HIGH
                                                      : tfc_pkg::CONF_MED};
         else
            diag = '{tfc_pkg::CASE_FIN_NOBIDIR, tfc_pkg::LVL_WARNING, tfc_pkg::CONF_MED};
      end else if (view.syn_nz && !view.synack_nz) begin
         diag = '{tfc_pkg::CASE_SYN_UNANS, tfc_pkg::LVL_WARNING,
                  view.syn_many ? tfc_pkg::CONF_HIGH : tfc_pkg::CONF_MED};
      end else if (view.synack_nz && !view.hs) begin
         diag = '{tfc_pkg::CASE_HALF_HS, tfc_pkg::LVL_WARNING, tfc_pkg::CONF_HIGH};
      end else if (view.hs) begin
         if (both_pl)
            diag = '{tfc_pkg::CASE_EST_BIDIR, tfc_pkg::LVL_NORMAL, tfc_pkg::CONF_HIGH};
         else if (any_pl)
            diag = '{tfc_pkg::CASE_EST_ONEWAY, tfc_pkg::LVL_WARNING, tfc_pkg::CONF_MED};
         else
            diag = '{tfc_pkg::CASE_EST_IDLE, tfc_pkg::LVL_NORMAL,
                     view.syn_nz ? tfc_pkg::CONF_HIGH : tfc_pkg::CONF_MED};
      end else if (any_pl) begin
         if (both_pl)
            diag = '{tfc_pkg::CASE_MID_BIDIR, tfc_pkg::LVL_NORMAL, tfc_pkg::CONF_MED};
         else
            diag = '{tfc_pkg::CASE_MID_ONEWAY, tfc_pkg::LVL_WARNING, tfc_pkg::CONF_LOW};
      end else begin
         diag = '{tfc_pkg::CASE_INSUFFICIENT, tfc_pkg::LVL_UNKNOWN, tfc_pkg::CONF_LOW};
      end
   end
endmodule

>>> dv/tcp_flow_tracker_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// tcp_flow_tracker_classifier_core_tb
// self-checking bench for the tcp flow tracker and classifier core
// ----------------------------------------------------------------------------
// Headers are driven on the req_ side under random idling and stalling. A
// behavioural flow table inside the bench predicts each result transaction;
// results are checked field by field, in order, against a queue of expected
// diagnoses. Directed sequences cover the filter, most diagnosis cases and a
// full table; random phases run well-formed headers plus noise under several
// filter settings.
module tcp_flow_tracker_classifier_core_tb;

   localparam int SLOTS = 16;
   localparam logic [15:0] CNT_SAT = 16'hFFFF;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic        pkt_valid;
      logic [1:0]  proto;
      logic [31:0] sa;
      logic [15:0] sp;
      logic [31:0] da;
      logic [15:0] dp;
      logic [7:0]  flags;
      logic [15:0] plen;
   } hdr_type;

   typedef struct packed {
      logic       accepted;
      logic       tracked;
      logic       table_full;
      logic       new_flow;
      logic [3:0] slot;
      logic       origin_known;
      logic       hs_done;
      logic [3:0] dcase;
      logic [1:0] level;
      logic [1:0] conf;
   } verdict_type;

   localparam int HDR_BITS = $bits(hdr_type);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   hdr_type req_hdr = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   verdict_type got;

   tcp_flow_tracker_classifier_core dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pkt_valid(req_hdr.pkt_valid), .req_proto_kind(req_hdr.proto),
      .req_src_addr(req_hdr.sa), .req_src_port_num(req_hdr.sp),
      .req_dst_addr(req_hdr.da), .req_dst_port_num(req_hdr.dp),
      .req_flag_bits(req_hdr.flags), .req_payload_len(req_hdr.plen),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_accepted(got.accepted), .rsp_tracked(got.tracked),
      .rsp_table_full(got.table_full), .rsp_new_flow(got.new_flow),
      .rsp_slot_index(got.slot), .rsp_origin_known(got.origin_known),
      .rsp_handshake_done(got.hs_done), .rsp_diag_case(got.dcase),
      .rsp_diag_level(got.level), .rsp_diag_confidence(got.conf)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // shadow copy of the filter registers
   logic [31:0] m_peer_ip;
   logic        m_filter_on, m_need_port;
   logic [15:0] m_peer_port;

   // shadow flow table
   logic        t_used [SLOTS];
   logic [31:0] t_iip [SLOTS], t_rip [SLOTS];
   logic [15:0] t_iport [SLOTS], t_rport [SLOTS];
   logic        t_known [SLOTS], t_hs [SLOTS];
   logic [15:0] t_syn [SLOTS], t_synack [SLOTS], t_rst_i [SLOTS], t_rst_r [SLOTS];
   logic [15:0] t_fin_i [SLOTS], t_fin_r [SLOTS];
   logic [1:0]  t_first_rst [SLOTS];
   logic [31:0] t_dat_i [SLOTS], t_dat_r [SLOTS];

   verdict_type expected_q[$];
   int  mismatches = 0;
   int  n_sent = 0, n_checked = 0, n_full = 0;
   int  send_idle = 0, recv_idle = 0;
   longint cycles = 0;
   int  case_hits [16];

   function automatic logic passes_filter(hdr_type h);
      if (!h.pkt_valid) return 1'b0;
      if (m_filter_on && h.sa != m_peer_ip && h.da != m_peer_ip) return 1'b0;
      if (m_need_port) begin
         if (h.proto != tfc_pkg::PROTO_TCP) return h.proto == tfc_pkg::PROTO_ICMP;
         if (m_peer_port == 16'd0) return 1'b0;
         if (h.sp != m_peer_port && h.dp != m_peer_port) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [15:0] bump16(logic [15:0] v);
      return (v == CNT_SAT) ? v : v + 16'd1;
   endfunction

   function automatic logic [31:0] bump32(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // diagnosis of slot s after its update
   function automatic void diagnose(int s, output logic [3:0] c,
                                    output logic [1:0] lv, output logic [1:0] cf);
      logic any_pl, both_pl, any_rst, any_fin;
      any_pl  = t_dat_i[s] != 0 || t_dat_r[s] != 0;
      both_pl = t_dat_i[s] != 0 && t_dat_r[s] != 0;
      any_rst = t_rst_i[s] != 0 || t_rst_r[s] != 0;
      any_fin = t_fin_i[s] != 0 || t_fin_r[s] != 0;
      if (any_rst) begin
         if (t_known[s] && t_first_rst[s] == tfc_pkg::RST_RESP && !t_hs[s] &&
             t_syn[s] != 0 && t_synack[s] == 0) begin
            c = tfc_pkg::CASE_REFUSED; lv = tfc_pkg::LVL_ERROR; cf = tfc_pkg::CONF_HIGH;
         end else if (both_pl) begin
            c = tfc_pkg::CASE_RST_DATA; lv = tfc_pkg::LVL_WARNING; cf = tfc_pkg::CONF_HIGH;
         end else begin
            c = tfc_pkg::CASE_ABN_RST; lv = tfc_pkg::LVL_ERROR; cf = tfc_pkg::CONF_HIGH;
         end
      end else if (any_fin && (t_hs[s] || any_pl)) begin
         if (both_pl) begin
            c = tfc_pkg::CASE_CLOSED; lv = tfc_pkg::LVL_NORMAL;
            cf = (t_fin_i[s] != 0 && t_fin_r[s] != 0) ? tfc_pkg::CONF_HIGH
                                                      : tfc_pkg::CONF_MED;
         end else begin
            c = tfc_pkg::CASE_FIN_NOBIDIR; lv = tfc_pkg::LVL_WARNING; cf = tfc_pkg::CONF_MED;
         end
      end else if (t_syn[s] != 0 && t_synack[s] == 0) begin
         c = tfc_pkg::CASE_SYN_UNANS; lv = tfc_pkg::LVL_WARNING;
         cf = (t_syn[s] >= 16'(tfc_pkg::SYN_MANY)) ? tfc_pkg::CONF_HIGH : tfc_pkg::CONF_MED;
      end else if (t_synack[s] != 0 && !t_hs[s]) begin
         c = tfc_pkg::CASE_HALF_HS; lv = tfc_pkg::LVL_WARNING; cf = tfc_pkg::CONF_HIGH;
      end else if (t_hs[s]) begin
         if (both_pl) begin
            c = tfc_pkg::CASE_EST_BIDIR; lv = tfc_pkg::LVL_NORMAL; cf = tfc_pkg::CONF_HIGH;
         end else if (any_pl) begin
            c = tfc_pkg::CASE_EST_ONEWAY; lv = tfc_pkg::LVL_WARNING; cf = tfc_pkg::CONF_MED;
         end else begin
            c = tfc_pkg::CASE_EST_IDLE; lv = tfc_pkg::LVL_NORMAL;
            cf = (t_syn[s] != 0) ? tfc_pkg::CONF_HIGH : tfc_pkg::CONF_MED;
         end
      end else if (any_pl) begin
         if (both_pl) begin
            c = tfc_pkg::CASE_MID_BIDIR; lv = tfc_pkg::LVL_NORMAL; cf = tfc_pkg::CONF_MED;
         end else begin
            c = tfc_pkg::CASE_MID_ONEWAY; lv = tfc_pkg::LVL_WARNING; cf = tfc_pkg::CONF_LOW;
         end
      end else begin
         c = tfc_pkg::CASE_INSUFFICIENT; lv = tfc_pkg::LVL_UNKNOWN; cf = tfc_pkg::CONF_LOW;
      end
   endfunction

   // applies one header to the shadow table and returns the verdict
   function automatic verdict_type track_header(hdr_type h);
      verdict_type v;
      int s;
      logic hit, fresh, syn, ack, from_i, from_r;
      v = '0;
      s = 0; hit = 1'b0; fresh = 1'b0;
      syn = (h.flags & tfc_pkg::FL_SYN) != 0;
      ack = (h.flags & tfc_pkg::FL_ACK) != 0;
      if (!passes_filter(h)) return v;
      v.accepted = 1'b1;
      v.dcase = tfc_pkg::CASE_INSUFFICIENT;
      v.level = tfc_pkg::LVL_UNKNOWN;
      v.conf  = tfc_pkg::CONF_LOW;
      if (h.proto != tfc_pkg::PROTO_TCP) return v;
      for (int i = 0; i < SLOTS && !hit; i++) begin
         if (t_used[i] &&
             ((h.sa == t_iip[i] && h.sp == t_iport[i] &&
               h.da == t_rip[i] && h.dp == t_rport[i]) ||
              (h.sa == t_rip[i] && h.sp == t_rport[i] &&
               h.da == t_iip[i] && h.dp == t_iport[i])))
         begin
            hit = 1'b1; s = i;
         end
      end
      for (int i = 0; i < SLOTS && !hit; i++) begin
         if (!t_used[i]) begin
            hit = 1'b1; fresh = 1'b1; s = i;
            t_used[i] = 1'b1;
            // a syn/ack opener names the destination as initiator
            if (syn && ack) begin
               t_iip[i] = h.da; t_iport[i] = h.dp; t_rip[i] = h.sa; t_rport[i] = h.sp;
               t_known[i] = 1'b1;
            end else begin
               t_iip[i] = h.sa; t_iport[i] = h.sp; t_rip[i] = h.da; t_rport[i] = h.dp;
               t_known[i] = syn && !ack;
            end
            t_syn[i] = 0; t_synack[i] = 0; t_hs[i] = 1'b0;
            t_rst_i[i] = 0; t_rst_r[i] = 0; t_first_rst[i] = tfc_pkg::RST_NONE;
            t_fin_i[i] = 0; t_fin_r[i] = 0; t_dat_i[i] = 0; t_dat_r[i] = 0;
         end
      end
      if (!hit) begin
         v.table_full = 1'b1;
         return v;
      end
      from_i = h.sa == t_iip[s] && h.sp == t_iport[s];
      from_r = h.sa == t_rip[s] && h.sp == t_rport[s];
      if (syn && !ack) begin
         if (from_i) begin
            t_known[s] = 1'b1; t_syn[s] = bump16(t_syn[s]);
         end
      end else if (syn && ack) begin
         if (from_r) t_synack[s] = bump16(t_synack[s]);
      end else if (ack) begin
         if (from_i && t_synack[s] != 0) t_hs[s] = 1'b1;
      end
      if ((h.flags & tfc_pkg::FL_RST) != 0) begin
         if (t_first_rst[s] == tfc_pkg::RST_NONE)
            t_first_rst[s] = from_r ? tfc_pkg::RST_RESP : tfc_pkg::RST_INIT;
         if (from_i) t_rst_i[s] = bump16(t_rst_i[s]);
         else if (from_r) t_rst_r[s] = bump16(t_rst_r[s]);
      end
      if ((h.flags & tfc_pkg::FL_FIN) != 0) begin
         if (from_i) t_fin_i[s] = bump16(t_fin_i[s]);
         else if (from_r) t_fin_r[s] = bump16(t_fin_r[s]);
      end
      if (h.plen != 0) begin
         if (from_i) t_dat_i[s] = bump32(t_dat_i[s]);
         else if (from_r) t_dat_r[s] = bump32(t_dat_r[s]);
      end
      v.tracked = 1'b1;
      v.new_flow = fresh;
      v.slot = 4'(s);
      v.origin_known = t_known[s];
      v.hs_done = t_hs[s];
      diagnose(s, v.dcase, v.level, v.conf);
      return v;
   endfunction

   // ---------------------------------------------------------------- driving

   // one header transaction; valid is held across back-to-back sends
   task automatic send_header(hdr_type h);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_hdr <= h;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(track_header(h));
      n_sent++;
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write enable is left high; the caller drops it after the last write
   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      unique case (idx)
         tfc_pkg::CSR_PEER_IP:     m_peer_ip = val;
         tfc_pkg::CSR_FILTER_ON:   m_filter_on = val[0];
         tfc_pkg::CSR_REQUIRE_PRT: m_need_port = val[0];
         tfc_pkg::CSR_PEER_PORT:   m_peer_port = val[15:0];
         default: ;
      endcase
   endtask

   task automatic set_filter(logic [31:0] ip, logic on, logic need, logic [15:0] port);
      go_idle();
      write_reg(tfc_pkg::CSR_PEER_IP, ip);
      write_reg(tfc_pkg::CSR_FILTER_ON, {31'd0, on});
      write_reg(tfc_pkg::CSR_REQUIRE_PRT, {31'd0, need});
      write_reg(tfc_pkg::CSR_PEER_PORT, {16'd0, port});
      csr_wr_en <= 1'b0;
   endtask

   function automatic hdr_type tcp(logic [31:0] sa, logic [15:0] sp, logic [31:0] da,
                                   logic [15:0] dp, logic [7:0] fl, logic [15:0] pl);
      hdr_type h;
      h.pkt_valid = 1'b1; h.proto = tfc_pkg::PROTO_TCP;
      h.sa = sa; h.sp = sp; h.da = da; h.dp = dp; h.flags = fl; h.plen = pl;
      return h;
   endfunction

   // ----------------------------------------------------------------- checking

   always @(posedge clock) begin
      verdict_type exp_v;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction %h", got);
         end else begin
            exp_v = expected_q.pop_front();
            n_checked++;
            case_hits[got.dcase]++;
            if (got !== exp_v) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch #%0d: acc/trk/full/new %b%b%b%b exp %b%b%b%b, %s",
                     n_checked, got.accepted, got.tracked, got.table_full, got.new_flow,
                     exp_v.accepted, exp_v.tracked, exp_v.table_full, exp_v.new_flow,
                     "details below");
                  $display("   slot %0d exp %0d, known/hs %b%b exp %b%b",
                     got.slot, exp_v.slot, got.origin_known, got.hs_done,
                     exp_v.origin_known, exp_v.hs_done);
                  $display("   case %0d/%0d/%0d exp %0d/%0d/%0d",
                     got.dcase, got.level, got.conf,
                     exp_v.dcase, exp_v.level, exp_v.conf);
               end
            end
         end
      end
   end

   // receiver stalls at random while recv_idle is set
   always @(posedge clock) begin
      cycles++;
      rsp_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------- tests

   // filter edge cases, every flag and field extreme
   task automatic test_filter();
      hdr_type h;
      set_filter(32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF);
      h = tcp(32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 8'hFF, 16'hFFFF);
      send_header(h);
      h.pkt_valid = 1'b0; send_header(h);
      h = tcp(32'h1, 16'd5, 32'h2, 16'hFFFF, 8'h00, 16'd0);
      send_header(h);                                 // peer ip missing
      h.proto = tfc_pkg::PROTO_ICMP; h.sa = 32'hFFFF_FFFF; send_header(h);
      h.proto = 2'd2; send_header(h);
      h.proto = 2'd3; send_header(h);
      set_filter(32'h0, 1'b0, 1'b1, 16'd0);          // port zero refuses tcp
      send_header(tcp(32'h5, 16'd1, 32'h6, 16'd0, tfc_pkg::FL_SYN, 16'd0));
      set_filter(32'h0, 1'b0, 1'b0, 16'd0);
      h = tcp(32'h7, 16'd2, 32'h8, 16'd3, 8'h00, 16'd0);
      h.proto = 2'd3; send_header(h);                 // untracked other protocol
   endtask

   // most of the diagnosis cases on separate flows
   task automatic test_diagnoses();
      set_filter(32'h0, 1'b0, 1'b0, 16'd0);
      // refused: syn then rst from responder
      send_header(tcp(32'hA, 16'd100, 32'hB, 16'd80, tfc_pkg::FL_SYN, 16'd0));
      send_header(tcp(32'hB, 16'd80, 32'hA, 16'd100,
                      tfc_pkg::FL_RST | tfc_pkg::FL_ACK, 16'd0));
      // full handshake, bidir data, fins both ways, then rst
      send_header(tcp(32'hC, 16'd200, 32'hD, 16'd443, tfc_pkg::FL_SYN, 16'd0));
      send_header(tcp(32'hD, 16'd443, 32'hC, 16'd200,
                      tfc_pkg::FL_SYN | tfc_pkg::FL_ACK, 16'd0));
      send_header(tcp(32'hC, 16'd200, 32'hD, 16'd443, tfc_pkg::FL_ACK, 16'd0));
      send_header(tcp(32'hC, 16'd200, 32'hD, 16'd443, tfc_pkg::FL_ACK, 16'd10));
      send_header(tcp(32'hD, 16'd443, 32'hC, 16'd200, tfc_pkg::FL_ACK, 16'd20));
      send_header(tcp(32'hC, 16'd200, 32'hD, 16'd443,
                      tfc_pkg::FL_FIN | tfc_pkg::FL_ACK, 16'd0));
      send_header(tcp(32'hD, 16'd443, 32'hC, 16'd200,
                      tfc_pkg::FL_FIN | tfc_pkg::FL_ACK, 16'd0));
      send_header(tcp(32'hC, 16'd200, 32'hD, 16'd443, tfc_pkg::FL_RST, 16'd0));
      // half handshake opened by syn/ack, then mid-stream data
      send_header(tcp(32'hE, 16'd1, 32'hF, 16'd2,
                      tfc_pkg::FL_SYN | tfc_pkg::FL_ACK, 16'd0));
      send_header(tcp(32'h10, 16'd3, 32'h11, 16'd4, 8'h00, 16'd5));
      send_header(tcp(32'h11, 16'd4, 32'h10, 16'd3, tfc_pkg::FL_FIN, 16'd5));
      // endpoint on both sides of its own flow
      send_header(tcp(32'h12, 16'd9, 32'h12, 16'd9, tfc_pkg::FL_RST, 16'd0));
      // repeated syn
      repeat (3) send_header(tcp(32'h13, 16'd7, 32'h14, 16'd8, tfc_pkg::FL_SYN, 16'd0));
   endtask

   // fill the table and overflow it
   task automatic test_table_full();
      set_filter(32'h0, 1'b0, 1'b0, 16'd0);
      for (int i = 0; i < SLOTS + 3; i++)
         send_header(tcp(32'h100 + i, 16'(i), 32'h200, 16'd22, tfc_pkg::FL_SYN, 16'd0));
   endtask

   // random headers; flows drawn from a small endpoint pool
   task automatic test_random(int count);
      hdr_type h;
      logic [31:0] ips [4];
      logic [15:0] ports [4];
      logic [7:0] fl_pick [6];
      fl_pick = '{tfc_pkg::FL_SYN, tfc_pkg::FL_SYN | tfc_pkg::FL_ACK, tfc_pkg::FL_ACK,
                  tfc_pkg::FL_FIN | tfc_pkg::FL_ACK, tfc_pkg::FL_RST,
                  tfc_pkg::FL_ACK | tfc_pkg::FL_RST};
      ips = '{m_peer_ip, 32'h0A00_0001, 32'hC0A8_0101, 32'hFFFF_FFFE};
      ports = '{m_peer_port, 16'd80, 16'd1025, 16'hFFFF};
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) < 8) begin
            h = tcp(ips[$urandom_range(3)], ports[$urandom_range(3)],
                    ips[$urandom_range(3)], ports[$urandom_range(3)],
                    fl_pick[$urandom_range(5)],
                    $urandom_range(1) ? 16'd0 : 16'($urandom));
            if ($urandom_range(19) == 0) h.proto = 2'($urandom);
         end else begin
            h = hdr_type'(HDR_BITS'({$urandom, $urandom, $urandom, $urandom}));
            h.pkt_valid = $urandom_range(7) != 0;
         end
         send_header(h);
      end
   endtask

   initial begin
      m_peer_ip = '0; m_filter_on = 1'b0; m_need_port = 1'b0; m_peer_port = '0;
      foreach (t_used[i]) t_used[i] = 1'b0;
      foreach (case_hits[i]) case_hits[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_filter();
      test_diagnoses();
      test_table_full();

      // table stays full from here; a fresh reset is not allowed, so the
      // random phases exercise matching against the occupied slots and overflow
      send_idle = 14; recv_idle = 83;
      set_filter(32'h0A00_0001, 1'b1, 1'b0, 16'd80);
      test_random(240);
      send_idle = 83; recv_idle = 14;
      set_filter(32'hC0A8_0101, 1'b0, 1'b1, 16'd80);
      test_random(230);
      send_idle = 0; recv_idle = 0;
      set_filter(32'hFFFF_FFFE, 1'b1, 1'b1, 16'hFFFF);
      test_random(230);

      go_idle();
      $display("sent %0d headers, checked %0d results under three filter settings",
               n_sent, n_checked);
      $display("diagnosis cases seen: refused %0d, closed %0d, est %0d, insufficient %0d",
               case_hits[0], case_hits[3], case_hits[7], case_hits[12]);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> tcp_flow_tracker_classifier_core.f
design/tfc_pkg.sv
design/tfc_classify.sv
design/tcp_flow_tracker_classifier_core.sv
dv/tcp_flow_tracker_classifier_core_tb.sv
